/* rtl/tlrq_pkg.sv */
package tlrq_pkg;

    localparam int TASKS = 32;
    localparam int CPUS  = 8;
    localparam int NQ    = CPUS + 1;
    localparam int GQ    = CPUS;
    localparam int ID_W  = $clog2(TASKS);
    localparam int Q_W   = $clog2(NQ);

    localparam logic [2:0] OP_ADD_GLOBAL  = 3'd0;
    localparam logic [2:0] OP_ADD_LOCAL   = 3'd1;
    localparam logic [2:0] OP_TAKE_GLOBAL = 3'd2;
    localparam logic [2:0] OP_TAKE_LOCAL  = 3'd3;
    localparam logic [2:0] OP_SWITCH      = 3'd4;
    localparam logic [2:0] OP_MOVE        = 3'd5;

    localparam logic [1:0] TS_CREATED = 2'd0;
    localparam logic [1:0] TS_READY   = 2'd1;
    localparam logic [1:0] TS_RUNNING = 2'd2;

    typedef struct packed {
        logic [2:0] op;
        logic [4:0] task_id;
        logic [2:0] cpu;
    } req_t;

    typedef struct packed {
        logic [4:0] result_task;
        logic       task_found;
        logic [1:0] result_state;
        logic [4:0] running_task;
        logic       running_valid;
        logic       status;
    } res_t;

    typedef struct packed {
        logic load;
        logic step;
        logic fallback;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic need_global;
    } sts_t;

endpackage

/* rtl/tlrq_ctrl.sv */
module tlrq_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    output tlrq_pkg::cmd_t  cmd,
    input  tlrq_pkg::sts_t  sts
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_FALL = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next   = state_reg;
        cmd.load     = 1'b0;
        cmd.step     = 1'b0;
        cmd.fallback = 1'b0;
        cmd.finish   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.step = 1'b1;
                if (sts.need_global)
                begin
                    state_next = ST_FALL;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_FALL:
            begin
                cmd.fallback = 1'b1;
                cmd.finish   = 1'b1;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == ST_EXEC))
        else $error("accepted word did not enter execution");

    a_fall_after_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FALL) |-> ($past(state_reg) == ST_EXEC && $past(sts.need_global)))
        else $error("global fallback without a local miss");

    a_single_finish: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> !cmd.finish)
        else $error("two results for one word");

endmodule

/* rtl/tlrq_dp.sv */
module tlrq_dp
(
    input  logic            clk,
    input  logic            rst_n,
    input  tlrq_pkg::req_t  req,
    input  tlrq_pkg::cmd_t  cmd,
    output tlrq_pkg::sts_t  sts,
    output logic            done,
    output tlrq_pkg::res_t  res
);

    tlrq_pkg::req_t req_reg;

    logic [tlrq_pkg::ID_W-1:0] link_reg [tlrq_pkg::TASKS];
    logic [tlrq_pkg::ID_W-1:0] link_next [tlrq_pkg::TASKS];
    logic [tlrq_pkg::TASKS-1:0] end_reg;
    logic [tlrq_pkg::TASKS-1:0] end_next;
    logic [1:0] stat_reg [tlrq_pkg::TASKS];
    logic [1:0] stat_next [tlrq_pkg::TASKS];
    logic [tlrq_pkg::ID_W-1:0] head_reg [tlrq_pkg::NQ];
    logic [tlrq_pkg::ID_W-1:0] head_next [tlrq_pkg::NQ];
    logic [tlrq_pkg::ID_W-1:0] tail_reg [tlrq_pkg::NQ];
    logic [tlrq_pkg::ID_W-1:0] tail_next [tlrq_pkg::NQ];
    logic [tlrq_pkg::NQ-1:0] nonempty_reg;
    logic [tlrq_pkg::NQ-1:0] nonempty_next;
    logic [tlrq_pkg::ID_W-1:0] run_id_reg;
    logic [tlrq_pkg::ID_W-1:0] run_id_next;
    logic run_flag_reg;
    logic run_flag_next;
    logic done_reg;
    tlrq_pkg::res_t res_reg;

    logic cpu_ok;
    logic tid_ok;
    logic [tlrq_pkg::Q_W-1:0] cpu_q;
    logic [tlrq_pkg::Q_W-1:0] glob_q;
    logic [tlrq_pkg::ID_W-1:0] tid;
    logic app_en;
    logic [tlrq_pkg::Q_W-1:0] app_q;
    logic [tlrq_pkg::ID_W-1:0] app_t;
    logic pop_en;
    logic [tlrq_pkg::Q_W-1:0] pop_q;
    logic clr_en;
    logic sw;
    logic found;
    logic [tlrq_pkg::ID_W-1:0] pick;
    logic err;
    logic [1:0] res_state;

    assign cpu_ok = (32'(req_reg.cpu) < tlrq_pkg::CPUS);
    assign tid_ok = (32'(req_reg.task_id) < tlrq_pkg::TASKS);
    assign cpu_q  = tlrq_pkg::Q_W'(req_reg.cpu);
    assign glob_q = tlrq_pkg::Q_W'(tlrq_pkg::GQ);
    assign tid    = tlrq_pkg::ID_W'(req_reg.task_id);

    always_comb
    begin
        link_next     = link_reg;
        end_next      = end_reg;
        stat_next     = stat_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        nonempty_next = nonempty_reg;
        run_id_next   = run_id_reg;
        run_flag_next = run_flag_reg;
        app_en        = 1'b0;
        app_q         = glob_q;
        app_t         = tid;
        pop_en        = 1'b0;
        pop_q         = glob_q;
        clr_en        = 1'b0;
        sw            = 1'b0;
        found         = 1'b0;
        pick          = '0;
        err           = 1'b0;
        res_state     = tlrq_pkg::TS_CREATED;

        if (cmd.step)
        begin
            case (req_reg.op)
                tlrq_pkg::OP_ADD_GLOBAL:
                begin
                    app_en = tid_ok;
                end
                tlrq_pkg::OP_ADD_LOCAL:
                begin
                    app_en = tid_ok && cpu_ok;
                    app_q  = cpu_q;
                end
                tlrq_pkg::OP_TAKE_GLOBAL:
                begin
                    pop_en = 1'b1;
                end
                tlrq_pkg::OP_TAKE_LOCAL:
                begin
                    pop_en = cpu_ok;
                    pop_q  = cpu_q;
                end
                tlrq_pkg::OP_SWITCH:
                begin
                    pop_en = cpu_ok;
                    pop_q  = cpu_q;
                    sw     = 1'b1;
                end
                tlrq_pkg::OP_MOVE:
                begin
                    if (!run_flag_reg)
                    begin
                        err = 1'b1;
                    end
                    else
                    begin
                        stat_next[run_id_reg] = tlrq_pkg::TS_READY;
                        app_en        = 1'b1;
                        app_t         = run_id_reg;
                        clr_en        = cpu_ok;
                        run_id_next   = '0;
                        run_flag_next = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.fallback)
        begin
            pop_en = 1'b1;
            sw     = 1'b1;
        end

        if (app_en)
        begin
            end_next[app_t] = 1'b1;
            if (nonempty_reg[app_q])
            begin
                link_next[tail_reg[app_q]] = app_t;
                end_next[tail_reg[app_q]]  = 1'b0;
                tail_next[app_q]           = app_t;
            end
            else
            begin
                head_next[app_q]     = app_t;
                tail_next[app_q]     = app_t;
                nonempty_next[app_q] = 1'b1;
            end
        end

        if (pop_en && nonempty_reg[pop_q])
        begin
            found = 1'b1;
            pick  = head_reg[pop_q];
            if (end_reg[pick])
            begin
                nonempty_next[pop_q] = 1'b0;
                head_next[pop_q]     = '0;
                tail_next[pop_q]     = '0;
            end
            else
            begin
                head_next[pop_q] = link_reg[pick];
            end
        end

        if (clr_en)
        begin
            nonempty_next[cpu_q] = 1'b0;
            head_next[cpu_q]     = '0;
            tail_next[cpu_q]     = '0;
        end

        if (sw && found)
        begin
            if (!(run_flag_reg && run_id_reg == pick))
            begin
                stat_next[pick] = tlrq_pkg::TS_RUNNING;
            end
            run_id_next   = pick;
            run_flag_next = 1'b1;
        end

        if (found)
        begin
            res_state = stat_next[pick];
        end
    end

    assign sts.need_global = cmd.step && sw && !found;

    always_ff @(posedge clk)
    begin
        link_reg <= link_next;
        if (cmd.load)
        begin
            req_reg <= req;
        end
        if (cmd.finish)
        begin
            res_reg.result_task   <= 5'(pick);
            res_reg.task_found    <= found;
            res_reg.result_state  <= res_state;
            res_reg.running_task  <= 5'(run_id_next);
            res_reg.running_valid <= run_flag_next;
            res_reg.status        <= err;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            end_reg      <= '1;
            nonempty_reg <= '0;
            run_id_reg   <= '0;
            run_flag_reg <= 1'b0;
            done_reg     <= 1'b0;
            for (int i = 0; i < tlrq_pkg::TASKS; i++)
            begin
                stat_reg[i] <= tlrq_pkg::TS_CREATED;
            end
            for (int i = 0; i < tlrq_pkg::NQ; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
            end
        end
        else
        begin
            end_reg      <= end_next;
            stat_reg     <= stat_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            nonempty_reg <= nonempty_next;
            run_id_reg   <= run_id_next;
            run_flag_reg <= run_flag_next;
            done_reg     <= cmd.finish;
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

    a_found_means_running: assert property (@(posedge clk) disable iff (!rst_n)
        (sw && found) |=> (run_flag_reg && stat_reg[run_id_reg] == tlrq_pkg::TS_RUNNING))
        else $error("switched task is not marked running");

    a_error_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        err |=> ($stable(run_flag_reg) && $stable(nonempty_reg)))
        else $error("failed move changed scheduler state");

    a_no_fallback_result: assert property (@(posedge clk) disable iff (!rst_n)
        sts.need_global |-> !cmd.finish)
        else $error("result issued before global fallback");

endmodule

/* rtl/two_level_ready_queue_scheduler.sv */
// Channel   Direction  Handshake               Word
// request   in         start high, busy low    req   (op, task_id, cpu)
// result    out        done, one cycle         res   (result_task .. status)
//
// An accepted word is registered, executed, and its result registered with the done strobe;
// a switch that finds its local queue empty, or names an invalid cpu, falls back to the global queue first.
// For a switch, the controller tries the local queue in its execute state and the global queue in its fallback state.
// A new word is accepted in the cycle its predecessor's result is shown.
// Reset empties every queue and clears the running task at once.
// The receiver cannot stall; done marks each result for exactly one cycle.
module two_level_ready_queue_scheduler
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  tlrq_pkg::req_t  req,
    output logic            done,
    output tlrq_pkg::res_t  res
);

    tlrq_pkg::cmd_t cmd;
    tlrq_pkg::sts_t sts;

    tlrq_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .sts   (sts)
    );

    tlrq_dp u_dp
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .sts   (sts),
        .done  (done),
        .res   (res)
    );

endmodule
